/* src/scfw_pkg.sv */
`timescale 1ns / 1ps
// Package of the sector cache: sizes, mode and action codes, and the
// command/status structs between controller and datapath. No dependencies.
package scfw_pkg;

  localparam int ENTRIES     = 64;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int SECTOR_W    = 32;
  localparam int MODE_W      = 3;
  localparam int ACTION_W    = 3;
  localparam int SLOT_W      = 6;
  localparam int MAX_RESULTS = 64;
  localparam int WB_W        = $clog2(MAX_RESULTS);

  localparam logic [MODE_W-1:0] MODE_READ  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLAIM = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AHEAD = 3'd4;

  localparam logic [ACTION_W-1:0] ACT_HIT       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CLAIM     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FETCH     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITEBACK = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_IDLE      = 3'd4;

  // Source of the fields of a pushed result
  typedef enum logic [2:0] {
    SRC_HIT,
    SRC_EVICT,
    SRC_INSTALL,
    SRC_WALK,
    SRC_IDLE
  } res_src_t;

  typedef struct packed {
    logic                load_req;
    logic                do_match;
    logic                push;
    res_src_t            res_src;
    logic [ACTION_W-1:0] res_action;
    logic                res_last;
    logic                set_dirty_hit;
    logic                do_install;
    logic                install_dirty;
    logic                arm_ahead;
    logic                disarm_ahead;
    logic                walk_init;
    logic                walk_step;
    logic                walk_clear;
    logic                ram_walk;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              hit;
    logic              full;
    logic              oldest_dirty;
    logic              walk_dirty;
    logic              any_dirty;
    logic              flush_last;
    logic              ahead_pending;
    logic              out_free;
  } sts_t;

endpackage

/* src/scfw_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels of the sector cache: request and result.
// Depends on scfw_pkg for field widths.
interface scfw_req_if;
  logic                           valid;
  logic                           ready;
  logic [scfw_pkg::MODE_W-1:0]    mode;
  logic [scfw_pkg::SECTOR_W-1:0]  sector;

  modport source (output valid, output mode, output sector, input ready);
  modport sink   (input valid, input mode, input sector, output ready);
endinterface

interface scfw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [scfw_pkg::ACTION_W-1:0]  action;
  logic [scfw_pkg::SECTOR_W-1:0]  target_sector;
  logic [scfw_pkg::SLOT_W-1:0]    slot;
  logic                           last;

  modport source (output valid, output action, output target_sector, output slot,
                  output last, input ready);
  modport sink   (input valid, input action, input target_sector, input slot,
                  input last, output ready);
endinterface

/* src/scfw_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module scfw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/scfw_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the sector cache: one-hot state machine that sequences
// lookup, eviction, install and the flush walk. Depends on scfw_pkg.
module scfw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  scfw_pkg::sts_t sts,
  output scfw_pkg::cmd_t cmd
);
  import scfw_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECODE  = 6'b000010,
    S_LOOKUP  = 6'b000100,
    S_INSTALL = 6'b001000,
    S_FL_READ = 6'b010000,
    S_FL_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   idle_res;

  always_comb begin
    cmd        = '0;
    state_next = state;
    idle_res   = 1'b0;
    in_ready   = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        case (sts.mode)
          MODE_READ, MODE_WRITE, MODE_CLAIM: begin
            cmd.do_match = 1'b1;
            state_next   = S_LOOKUP;
          end
          MODE_FLUSH: begin
            if (sts.any_dirty) begin
              cmd.walk_init = 1'b1;
              state_next    = S_FL_READ;
            end else begin
              idle_res = 1'b1;
            end
          end
          MODE_AHEAD: begin
            if (sts.ahead_pending) begin
              cmd.do_match = 1'b1;
              state_next   = S_LOOKUP;
            end else begin
              idle_res = 1'b1;
            end
          end
          default: idle_res = 1'b1;
        endcase
        if (idle_res && sts.out_free) begin
          cmd.push       = 1'b1;
          cmd.res_src    = SRC_IDLE;
          cmd.res_action = ACT_IDLE;
          cmd.res_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end

      S_LOOKUP: begin
        if (sts.hit) begin
          if (sts.out_free) begin
            cmd.push     = 1'b1;
            cmd.res_last = 1'b1;
            if (sts.mode == MODE_AHEAD) begin
              cmd.res_src      = SRC_IDLE;
              cmd.res_action   = ACT_IDLE;
              cmd.disarm_ahead = 1'b1;
            end else begin
              cmd.res_src       = SRC_HIT;
              cmd.res_action    = ACT_HIT;
              cmd.set_dirty_hit = (sts.mode == MODE_WRITE);
            end
            state_next = S_IDLE;
          end
        end else if (sts.full && sts.oldest_dirty) begin
          if (sts.out_free) begin
            cmd.push       = 1'b1;
            cmd.res_src    = SRC_EVICT;
            cmd.res_action = ACT_WRITEBACK;
            state_next     = S_INSTALL;
          end
        end else begin
          state_next = S_INSTALL;
        end
      end

      S_INSTALL: begin
        if (sts.out_free) begin
          cmd.push          = 1'b1;
          cmd.res_src       = SRC_INSTALL;
          cmd.res_action    = (sts.mode == MODE_CLAIM) ? ACT_CLAIM : ACT_FETCH;
          cmd.res_last      = 1'b1;
          cmd.do_install    = 1'b1;
          cmd.install_dirty = (sts.mode == MODE_WRITE);
          cmd.arm_ahead     = (sts.mode == MODE_READ);
          cmd.disarm_ahead  = (sts.mode == MODE_AHEAD);
          state_next        = S_IDLE;
        end
      end

      S_FL_READ: begin
        cmd.ram_walk = 1'b1;
        if (sts.walk_dirty) begin
          state_next = S_FL_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end

      S_FL_EMIT: begin
        cmd.ram_walk = 1'b1;
        if (sts.out_free) begin
          cmd.push       = 1'b1;
          cmd.res_src    = SRC_WALK;
          cmd.res_action = ACT_WRITEBACK;
          cmd.res_last   = sts.flush_last;
          cmd.walk_clear = 1'b1;
          if (sts.flush_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_step = 1'b1;
            state_next    = S_FL_READ;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> state == S_DECODE)
    else $error("request taken outside idle");
  a_walk_only_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_FL_READ || state == S_FL_EMIT) |-> sts.mode == MODE_FLUSH)
    else $error("flush walk for a non-flush request");
  a_emit_dirty: assert property (@(posedge clk) disable iff (rst)
    state == S_FL_EMIT |-> sts.walk_dirty)
    else $error("write back of a clean slot");

endmodule

/* src/scfw_dp.sv */
`timescale 1ns / 1ps
// Datapath of the sector cache: tag match array, tag RAM copy, dirty marks,
// FIFO pointers, read-ahead and result register. Depends on scfw_pkg, scfw_ram.
module scfw_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [scfw_pkg::MODE_W-1:0]    req_mode,
  input  logic [scfw_pkg::SECTOR_W-1:0]  req_sector,
  input  scfw_pkg::cmd_t                 cmd,
  output scfw_pkg::sts_t                 sts,
  scfw_rsp_if.source                     rsp
);
  import scfw_pkg::*;

  logic [MODE_W-1:0]   mode_q;
  logic [SECTOR_W-1:0] sector_q, key, key_q;
  logic [SECTOR_W-1:0] tags [ENTRIES];
  logic [ENTRIES-1:0]  dirty, valid_vec, match_d, match_q, walk_onehot;
  logic [CNT_W-1:0]    filled;
  logic [IDX_W-1:0]    oldest, oldest_inc, walk, walk_inc, hit_idx, inst_slot, ram_raddr;
  logic                full;
  logic                ahead_pending;
  logic [SECTOR_W-1:0] ahead_sector;
  logic [SECTOR_W-1:0] ram_rdata;
  logic [WB_W-1:0]     wb_count;
  logic                out_valid, out_free;
  logic [SECTOR_W-1:0] res_sector;
  logic [IDX_W-1:0]    res_idx;

  assign full        = (filled == CNT_W'(ENTRIES));
  assign key         = (mode_q == MODE_AHEAD) ? ahead_sector : sector_q;
  assign oldest_inc  = (oldest == IDX_W'(ENTRIES - 1)) ? '0 : oldest + 1'b1;
  assign walk_inc    = (walk == IDX_W'(ENTRIES - 1)) ? '0 : walk + 1'b1;
  assign inst_slot   = full ? oldest : filled[IDX_W-1:0];
  assign walk_onehot = {{(ENTRIES-1){1'b0}}, 1'b1} << walk;
  assign ram_raddr   = cmd.ram_walk ? walk : oldest;
  assign out_free    = !out_valid || rsp.ready;

  // Parallel compare of the in-use slots
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i] = (CNT_W'(i) < filled);
      match_d[i]   = valid_vec[i] && (tags[i] == key);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  scfw_ram #(.WIDTH(SECTOR_W), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.do_install),
    .waddr (inst_slot),
    .wdata (key_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.mode          = mode_q;
    sts.hit           = |match_q;
    sts.full          = full;
    sts.oldest_dirty  = dirty[oldest];
    sts.walk_dirty    = dirty[walk];
    sts.any_dirty     = |dirty;
    sts.flush_last    = ((dirty & ~walk_onehot) == '0) ||
                        (wb_count == WB_W'(MAX_RESULTS - 1));
    sts.ahead_pending = ahead_pending;
    sts.out_free      = out_free;
  end

  always_comb begin
    case (cmd.res_src)
      SRC_HIT: begin
        res_sector = key_q;
        res_idx    = hit_idx;
      end
      SRC_EVICT: begin
        res_sector = ram_rdata;
        res_idx    = oldest;
      end
      SRC_INSTALL: begin
        res_sector = key_q;
        res_idx    = inst_slot;
      end
      SRC_WALK: begin
        res_sector = ram_rdata;
        res_idx    = walk;
      end
      default: begin
        res_sector = '0;
        res_idx    = '0;
      end
    endcase
  end

  // Request and lookup payload, tag writes, flush walk pointer and write-back count
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_q   <= req_mode;
      sector_q <= req_sector;
    end
    if (cmd.do_match) begin
      key_q <= key;
    end
    if (cmd.do_install) begin
      tags[inst_slot] <= key_q;
    end
    if (cmd.walk_init) begin
      walk     <= oldest;
      wb_count <= '0;
    end else begin
      if (cmd.walk_step) begin
        walk <= walk_inc;
      end
      if (cmd.walk_clear) begin
        wb_count <= wb_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q       <= '0;
      dirty         <= '0;
      filled        <= '0;
      oldest        <= '0;
      ahead_pending <= 1'b0;
      ahead_sector  <= '0;
    end else begin
      if (cmd.do_match) begin
        match_q <= match_d;
      end
      if (cmd.set_dirty_hit) begin
        dirty[hit_idx] <= 1'b1;
      end
      if (cmd.walk_clear) begin
        dirty[walk] <= 1'b0;
      end
      if (cmd.do_install) begin
        dirty[inst_slot] <= cmd.install_dirty;
        if (full) begin
          oldest <= oldest_inc;
        end else begin
          filled <= filled + 1'b1;
        end
      end
      if (cmd.arm_ahead) begin
        ahead_pending <= 1'b1;
        ahead_sector  <= key_q + 1'b1;
      end else if (cmd.disarm_ahead) begin
        ahead_pending <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.action        <= cmd.res_action;
      rsp.target_sector <= res_sector;
      rsp.slot          <= SLOT_W'(res_idx);
      rsp.last          <= cmd.res_last;
    end
  end

  assign rsp.valid = out_valid;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= CNT_W'(ENTRIES))
    else $error("fill count beyond slot count");
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_q))
    else $error("sector held by two slots");
  a_oldest_until_full: assert property (@(posedge clk) disable iff (rst)
    !full |-> oldest == '0)
    else $error("oldest pointer moved before cache filled");
  a_dirty_in_use: assert property (@(posedge clk) disable iff (rst)
    (dirty & ~valid_vec) == '0)
    else $error("dirty mark on an unused slot");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> out_free)
    else $error("result pushed over a waiting result");

endmodule

/* src/sector_cache_fifo_writeback.sv */
`timescale 1ns / 1ps
// Sector cache tag/policy controller, FIFO replacement, write back.
// Usage:
//   req (sink): mode and sector. Modes: read, write, claim slot, flush tick,
//     read-ahead tick. A transaction is taken only while no request is in work.
//   rsp (source): device commands (action, target_sector, slot, last), one
//     transaction each, in order; last marks the final command of a request.
// Sequence, from the request transaction to the first command loaded into the
//   output register: an idle answer is pushed from the decode state (from the
//   lookup state for a read-ahead tick whose sector is already cached), a hit
//   from the lookup state, a miss from the install state, or from the lookup
//   state when a dirty slot is evicted (its write back first, then the fetch or
//   claim from the install state once the output register is free). Ready
//   returns as soon as the last command of a request is loaded.
//   Flush: the decode state, then a walk of the in-use slots oldest first, a
//   read state per slot and an emit state per dirty slot, until the last dirty
//   slot is written back. The control state machine and the single tag RAM read
//   port set this sequence.
// Lookup compares in-use tags in parallel with the sector or read-ahead sector.
// Reset: dirty marks, fill count, oldest pointer and read-ahead clear at once;
//   tags need no clearing since only in-use slots are compared or read.
// Stall: a finished command waits in the output register; the block holds
//   further commands of the same request until it is taken, while a new
//   request transaction can still be taken once the last command is loaded.
module sector_cache_fifo_writeback (
  input logic        clk,
  input logic        rst,
  scfw_req_if.sink   req,
  scfw_rsp_if.source rsp
);
  import scfw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence lookup, eviction, install and flush walk
  scfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold tags, dirty marks, pointers and the result register
  scfw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_mode   (req.mode),
    .req_sector (req.sector),
    .cmd        (cmd),
    .sts        (sts),
    .rsp        (rsp)
  );

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && !rsp.last) |-> !req.ready)
    else $error("request taken before its last command was issued");
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.action == ACT_IDLE) |-> (rsp.last && rsp.slot == '0))
    else $error("idle command with stray fields");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    ($past(rsp.valid && !rsp.ready) && !$past(rst)) |-> $stable(rsp.target_sector))
    else $error("stalled command changed");

endmodule

/* sim/scfw_cmd_checker.sv */
`timescale 1ns / 1ps
// Command checker for the sector cache: mirrors tags, dirty marks and read-ahead,
// predicts device commands per request and compares them. Depends on scfw_pkg, scfw_if.
module scfw_cmd_checker (
  input  logic clk,
  input  logic rst,
  scfw_req_if  req,
  scfw_rsp_if  rsp,
  output int   fails,
  output int   pending,
  output int   checked,
  output int   hits,
  output int   wbacks
);
  import scfw_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SECTOR_W-1:0] target_sector;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } dev_cmd_t;

  logic [SECTOR_W-1:0] tag_mem [ENTRIES];
  bit                  dirty_mem [ENTRIES];
  int                  fill_cnt;
  int                  oldest;
  bit                  ra_armed;
  logic [SECTOR_W-1:0] ra_sector;
  dev_cmd_t            cmd_q [$];

  function automatic dev_cmd_t mk_cmd(logic [ACTION_W-1:0] act, logic [SECTOR_W-1:0] sec,
                                      int s, logic lst);
    dev_cmd_t c;
    c.action        = act;
    c.target_sector = sec;
    c.slot          = SLOT_W'(s);
    c.last          = lst;
    return c;
  endfunction

  // Search in-use slots oldest first.
  function automatic int find_slot(logic [SECTOR_W-1:0] sec);
    int s;
    for (int i = 0; i < fill_cnt; i++) begin
      s = (oldest + i) % ENTRIES;
      if (tag_mem[s] == sec) return s;
    end
    return -1;
  endfunction

  // Take the next free slot, or evict the oldest (write back first if dirty).
  function automatic int take_slot(logic [SECTOR_W-1:0] sec);
    int s;
    if (fill_cnt < ENTRIES) begin
      s = fill_cnt;
      fill_cnt++;
    end else begin
      s = oldest;
      if (dirty_mem[s]) cmd_q.push_back(mk_cmd(ACT_WRITEBACK, tag_mem[s], s, 1'b0));
      oldest = (s + 1) % ENTRIES;
    end
    tag_mem[s]   = sec;
    dirty_mem[s] = 1'b0;
    return s;
  endfunction

  function automatic void predict_commands(logic [MODE_W-1:0] m, logic [SECTOR_W-1:0] sec);
    int s;
    int final_i;
    case (m)
      MODE_READ, MODE_WRITE, MODE_CLAIM: begin
        s = find_slot(sec);
        if (s >= 0) begin
          if (m == MODE_WRITE) dirty_mem[s] = 1'b1;
          cmd_q.push_back(mk_cmd(ACT_HIT, sec, s, 1'b1));
        end else begin
          s = take_slot(sec);
          if (m == MODE_CLAIM) begin
            cmd_q.push_back(mk_cmd(ACT_CLAIM, sec, s, 1'b1));
          end else begin
            cmd_q.push_back(mk_cmd(ACT_FETCH, sec, s, 1'b1));
            if (m == MODE_WRITE) begin
              dirty_mem[s] = 1'b1;
            end else begin
              ra_armed  = 1'b1;
              ra_sector = sec + 1'b1;
            end
          end
        end
      end
      MODE_FLUSH: begin
        final_i = -1;
        for (int i = 0; i < fill_cnt; i++)
          if (dirty_mem[(oldest + i) % ENTRIES]) final_i = i;
        if (final_i < 0) begin
          cmd_q.push_back(mk_cmd(ACT_IDLE, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i <= final_i; i++) begin
            s = (oldest + i) % ENTRIES;
            if (dirty_mem[s]) begin
              cmd_q.push_back(mk_cmd(ACT_WRITEBACK, tag_mem[s], s, i == final_i));
              dirty_mem[s] = 1'b0;
            end
          end
        end
      end
      MODE_AHEAD: begin
        if (ra_armed && find_slot(ra_sector) < 0) begin
          s = take_slot(ra_sector);
          cmd_q.push_back(mk_cmd(ACT_FETCH, ra_sector, s, 1'b1));
        end else begin
          cmd_q.push_back(mk_cmd(ACT_IDLE, '0, 0, 1'b1));
        end
        ra_armed = 1'b0;
      end
      default: cmd_q.push_back(mk_cmd(ACT_IDLE, '0, 0, 1'b1));
    endcase
  endfunction

  always @(posedge clk) begin
    dev_cmd_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) dirty_mem[i] = 1'b0;
      fill_cnt  = 0;
      oldest    = 0;
      ra_armed  = 1'b0;
      ra_sector = '0;
      cmd_q.delete();
    end else begin
      // Retire the command first: it can only belong to an earlier request.
      if (rsp.valid && rsp.ready) begin
        if (cmd_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t unexpected command: action %0d sector %h slot %0d last %0b",
                     $realtime, rsp.action, rsp.target_sector, rsp.slot, rsp.last);
        end else begin
          want = cmd_q.pop_front();
          checked++;
          if (want.action == ACT_HIT) hits++;
          if (want.action == ACT_WRITEBACK) wbacks++;
          if (rsp.action !== want.action || rsp.target_sector !== want.target_sector ||
              rsp.slot !== want.slot || rsp.last !== want.last) begin
            fails++;
            if (fails <= 10)
              $display("%0t command mismatch: expected %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
                       $realtime, want.action, want.target_sector, want.slot, want.last,
                       rsp.action, rsp.target_sector, rsp.slot, rsp.last);
          end
        end
      end
      if (req.valid && req.ready) predict_commands(req.mode, req.sector);
    end
    pending = cmd_q.size();
  end

endmodule

/* sim/tb_sector_cache_fifo_writeback.sv */
`timescale 1ns / 1ps
// Testbench top for the sector cache controller: drives requests, stalls the
// command channel and gives the verdict. Depends on scfw_pkg, scfw_if, scfw_cmd_checker.
module tb_sector_cache_fifo_writeback;
  import scfw_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES = 20;    // settle time after the last command
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 55;
  localparam int FILL_WRITES  = 70;    // more than ENTRIES, so dirty slots get evicted

  // Modes past the read-ahead tick are reserved and answer idle.
  localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = MODE_AHEAD + MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_RSVD_LAST  = '1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic rsp_ready = 1'b0;

  bit calm;          // no idling on either side while set
  int stall_left;
  int stall_draw;
  int idle_cycles;
  int sent;

  int fails, pending, checked, hits, wbacks;

  scfw_req_if req ();
  scfw_rsp_if rsp ();

  assign rsp.ready = rsp_ready;

  sector_cache_fifo_writeback u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  scfw_cmd_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .fails   (fails),
    .pending (pending),
    .checked (checked),
    .hits    (hits),
    .wbacks  (wbacks)
  );

  always #5 clk = ~clk;

  // Command sink: after each accepted transaction, drop ready for a random
  // number of cycles, then hold it high until the next command is taken.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else if (rsp_ready && rsp.valid) begin
      stall_draw = calm ? 0 : $urandom_range(0, 9);
      if (stall_draw != 0) begin
        rsp_ready  <= 1'b0;
        stall_left <= stall_draw - 1;
      end
    end else if (!rsp_ready) begin
      if (stall_left == 0) rsp_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request after a random gap and hold it until taken. Called
  // at a rising edge; returns at the edge where the transaction happened.
  task automatic send_req(input logic [MODE_W-1:0] m, input logic [SECTOR_W-1:0] sec);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.mode   <= m;
    req.sector <= sec;
    do @(posedge clk); while (req.ready !== 1'b1);
    sent++;
  endtask

  // Drop valid and wait until every predicted command has come back.
  task automatic hold_until_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random request: sectors mostly near a phase base so that hits, fills and
  // evictions all happen; some fully random and some at the top of the range.
  task automatic send_random(input logic [SECTOR_W-1:0] base, input int window);
    int r;
    logic [MODE_W-1:0]   m;
    logic [SECTOR_W-1:0] sec;
    r = $urandom_range(0, 99);
    if (r < 30)      m = MODE_READ;
    else if (r < 55) m = MODE_WRITE;
    else if (r < 68) m = MODE_CLAIM;
    else if (r < 76) m = MODE_FLUSH;
    else if (r < 94) m = MODE_AHEAD;
    else             m = MODE_AHEAD + MODE_W'($urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < 10)      sec = $urandom;
    else if (r < 14) sec = '1 - SECTOR_W'($urandom_range(0, 2));
    else             sec = base + SECTOR_W'($urandom_range(0, window - 1));
    send_req(m, sec);
  endtask

  initial begin
    logic [SECTOR_W-1:0] base;
    int window;
    req.valid  = 1'b0;
    req.mode   = MODE_READ;
    req.sector = '0;
    calm       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read-ahead wrapping past the top sector, idle ticks, hits,
    // claim, read-ahead of an already cached sector, flush and reserved modes.
    send_req(MODE_READ,  32'hFFFF_FFFF);   // miss, arms sector 0
    send_req(MODE_AHEAD, $urandom);        // fetch sector 0
    send_req(MODE_AHEAD, $urandom);        // nothing armed
    send_req(MODE_READ,  32'h0000_0000);   // hit
    send_req(MODE_WRITE, 32'h0000_0000);   // hit, mark dirty
    send_req(MODE_WRITE, 32'h0000_0001);   // miss, fetch then dirty
    send_req(MODE_CLAIM, 32'h8000_0000);   // claim without fetch
    send_req(MODE_CLAIM, 32'h8000_0000);   // hit
    send_req(MODE_READ,  32'h0000_0100);   // arms 0x101
    send_req(MODE_WRITE, 32'h0000_0101);   // caches the armed sector
    send_req(MODE_AHEAD, $urandom);        // already cached: idle
    send_req(MODE_READ,  32'h7FFF_FFFF);   // arms a cached sector
    send_req(MODE_AHEAD, $urandom);
    send_req(MODE_FLUSH, $urandom);        // three write-backs, oldest first
    send_req(MODE_FLUSH, $urandom);        // nothing dirty
    for (logic [MODE_W:0] m = MODE_RSVD_FIRST; m <= MODE_RSVD_LAST; m++)
      send_req(m[MODE_W-1:0], $urandom);
    send_req(MODE_WRITE, 32'hAAAA_AAAA);
    send_req(MODE_WRITE, 32'h5555_5555);
    send_req(MODE_FLUSH, $urandom);
    hold_until_drained();

    for (int p = 0; p < PHASES; p++) begin
      calm   = (p % 3 == 1);
      base   = $urandom;
      window = (p % 2 == 0) ? 96 : 40;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(base, window);
      hold_until_drained();
      if (p == 2) begin
        // Fill every slot dirty (evicting dirty slots on the way), then flush
        // the whole cache in one tick.
        for (int i = 0; i < FILL_WRITES; i++)
          send_req(MODE_WRITE, base + 32'h1000 + SECTOR_W'(i));
        send_req(MODE_FLUSH, $urandom);
        send_req(MODE_FLUSH, $urandom);
        hold_until_drained();
      end
    end

    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d requests; %0d device commands compared, %0d hits, %0d write-backs.",
             sent, checked, hits, wbacks);
    if (fails == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
